/* rtl/core/ray_triangle_nearest_hit_unit_assert.svh */
// Assertion macros for the ray/triangle nearest-hit unit.
// Included by modules that carry concurrent checks; needs clk and rst_n in scope.
`ifndef RAY_TRIANGLE_NEAREST_HIT_UNIT_ASSERT_SVH
`define RAY_TRIANGLE_NEAREST_HIT_UNIT_ASSERT_SVH

// same-cycle implication
`define RTNH_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define RTNH_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/core/rtnh_pkg.sv */
// Shared types, constants and micro-program for the ray/triangle nearest-hit unit.
// No dependencies.
package rtnh_pkg;

    localparam int FRAC_BITS    = 16;
    localparam int TAG_BITS_DEF = 16;
    localparam int COORD_W      = 32;
    localparam int DIST_W       = 31;
    localparam int PROD_W       = 2 * COORD_W;
    localparam int ACC_W        = PROD_W + 2;
    localparam int DOT_W        = PROD_W - FRAC_BITS + 2;
    localparam int DIV_W        = PROD_W;
    localparam int DSHIFT       = DIST_W - FRAC_BITS;
    localparam int NUM_STEPS    = 24;
    localparam int STEP_W       = 5;
    localparam int DCNT_W       = 5;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 32;

    localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
    localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
    localparam logic signed [ACC_W-1:0] SAT_HI = ACC_W'(64'sh7FFF_FFFF);
    localparam logic signed [ACC_W-1:0] SAT_LO = ACC_W'(-64'sh8000_0000);
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ORIGIN_X, CFG_ORIGIN_Y, CFG_ORIGIN_Z,
        CFG_DIR_X, CFG_DIR_Y, CFG_DIR_Z,
        CFG_DET_THR, CFG_MIN_DIST
    } cfg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE, ST_CALC, ST_NORM, ST_TEST, ST_DIV, ST_DONE
    } state_t;

    typedef enum logic [4:0] {
        SRC_DIR0, SRC_DIR1, SRC_DIR2,
        SRC_E1_0, SRC_E1_1, SRC_E1_2,
        SRC_E2_0, SRC_E2_1, SRC_E2_2,
        SRC_S0, SRC_S1, SRC_S2,
        SRC_H0, SRC_H1, SRC_H2,
        SRC_Q0, SRC_Q1, SRC_Q2
    } src_t;

    // cross: CLOAD then CSUB (writes cdst); dot: DLOAD, DADD, DEND (writes ddst)
    typedef enum logic [2:0] {
        OP_CLOAD, OP_CSUB, OP_DLOAD, OP_DADD, OP_DEND
    } mop_t;

    typedef enum logic [1:0] {
        DD_DET, DD_UN, DD_VN, DD_TN
    } ddst_t;

    typedef struct packed {
        src_t  a;
        src_t  b;
        mop_t  op;
        src_t  cdst;
        ddst_t ddst;
    } uop_t;

    typedef struct packed {
        logic              load;
        logic              issue;
        logic [STEP_W-1:0] step;
    } mac_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [ACC_W-1:0] x);
        priority if (x > SAT_HI)
            return COORD_MAX;
        else if (x < SAT_LO)
            return COORD_MIN;
        else
            return x[COORD_W-1:0];
    endfunction

    // h = dir x e2, det = e1.h, un = s.h, q = s x e1, vn = dir.q, tn = e2.q
    function automatic uop_t uop_rom(input logic [STEP_W-1:0] idx);
        uop_t r;
        unique case (idx)
            5'd0:  r = '{SRC_DIR1, SRC_E2_2, OP_CLOAD, SRC_H0, DD_DET};
            5'd1:  r = '{SRC_DIR2, SRC_E2_1, OP_CSUB,  SRC_H0, DD_DET};
            5'd2:  r = '{SRC_DIR2, SRC_E2_0, OP_CLOAD, SRC_H1, DD_DET};
            5'd3:  r = '{SRC_DIR0, SRC_E2_2, OP_CSUB,  SRC_H1, DD_DET};
            5'd4:  r = '{SRC_DIR0, SRC_E2_1, OP_CLOAD, SRC_H2, DD_DET};
            5'd5:  r = '{SRC_DIR1, SRC_E2_0, OP_CSUB,  SRC_H2, DD_DET};
            5'd6:  r = '{SRC_E1_0, SRC_H0,   OP_DLOAD, SRC_H0, DD_DET};
            5'd7:  r = '{SRC_E1_1, SRC_H1,   OP_DADD,  SRC_H0, DD_DET};
            5'd8:  r = '{SRC_E1_2, SRC_H2,   OP_DEND,  SRC_H0, DD_DET};
            5'd9:  r = '{SRC_S0,   SRC_H0,   OP_DLOAD, SRC_H0, DD_UN};
            5'd10: r = '{SRC_S1,   SRC_H1,   OP_DADD,  SRC_H0, DD_UN};
            5'd11: r = '{SRC_S2,   SRC_H2,   OP_DEND,  SRC_H0, DD_UN};
            5'd12: r = '{SRC_S1,   SRC_E1_2, OP_CLOAD, SRC_Q0, DD_UN};
            5'd13: r = '{SRC_S2,   SRC_E1_1, OP_CSUB,  SRC_Q0, DD_UN};
            5'd14: r = '{SRC_S2,   SRC_E1_0, OP_CLOAD, SRC_Q1, DD_UN};
            5'd15: r = '{SRC_S0,   SRC_E1_2, OP_CSUB,  SRC_Q1, DD_UN};
            5'd16: r = '{SRC_S0,   SRC_E1_1, OP_CLOAD, SRC_Q2, DD_UN};
            5'd17: r = '{SRC_S1,   SRC_E1_0, OP_CSUB,  SRC_Q2, DD_UN};
            5'd18: r = '{SRC_DIR0, SRC_Q0,   OP_DLOAD, SRC_Q0, DD_VN};
            5'd19: r = '{SRC_DIR1, SRC_Q1,   OP_DADD,  SRC_Q0, DD_VN};
            5'd20: r = '{SRC_DIR2, SRC_Q2,   OP_DEND,  SRC_Q0, DD_VN};
            5'd21: r = '{SRC_E2_0, SRC_Q0,   OP_DLOAD, SRC_Q0, DD_TN};
            5'd22: r = '{SRC_E2_1, SRC_Q1,   OP_DADD,  SRC_Q0, DD_TN};
            5'd23: r = '{SRC_E2_2, SRC_Q2,   OP_DEND,  SRC_Q0, DD_TN};
            default: r = '{SRC_DIR0, SRC_DIR0, OP_DADD, SRC_H0, DD_DET};
        endcase
        return r;
    endfunction

endpackage

/* rtl/core/rtnh_mac.sv */
// Shared 32x32 multiplier and accumulator stepping through the cross/dot micro-program.
// Depends on rtnh_pkg.
module rtnh_mac (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  rtnh_pkg::mac_ctrl_t                     ctrl,
    input  logic [2:0][rtnh_pkg::COORD_W-1:0]       dir,
    input  logic [2:0][rtnh_pkg::COORD_W-1:0]       e1,
    input  logic [2:0][rtnh_pkg::COORD_W-1:0]       e2,
    input  logic [2:0][rtnh_pkg::COORD_W-1:0]       sv,
    output logic signed [rtnh_pkg::DOT_W-1:0]       det,
    output logic signed [rtnh_pkg::DOT_W-1:0]       un,
    output logic signed [rtnh_pkg::DOT_W-1:0]       vn,
    output logic signed [rtnh_pkg::DOT_W-1:0]       tn
);
    import rtnh_pkg::*;

    logic [2:0][COORD_W-1:0]     e1_reg, e2_reg, s_reg, h_reg, q_reg;
    logic signed [PROD_W-1:0]    prod_reg;
    uop_t                        op_reg;
    logic                        opv_reg;
    logic signed [ACC_W-1:0]     acc_reg, acc_next;
    logic signed [ACC_W-1:0]     prod_ext, dterm;
    logic [COORD_W-1:0]          opa, opb, cross_val;
    uop_t                        uop;
    logic signed [DOT_W-1:0]     det_reg, un_reg, vn_reg, tn_reg;

    function automatic logic [COORD_W-1:0] pick(
        input src_t sel,
        input logic [2:0][COORD_W-1:0] d, a1, a2, s, h, q
    );
        logic [COORD_W-1:0] r;
        unique case (sel)
            SRC_DIR0: r = d[0];
            SRC_DIR1: r = d[1];
            SRC_DIR2: r = d[2];
            SRC_E1_0: r = a1[0];
            SRC_E1_1: r = a1[1];
            SRC_E1_2: r = a1[2];
            SRC_E2_0: r = a2[0];
            SRC_E2_1: r = a2[1];
            SRC_E2_2: r = a2[2];
            SRC_S0:   r = s[0];
            SRC_S1:   r = s[1];
            SRC_S2:   r = s[2];
            SRC_H0:   r = h[0];
            SRC_H1:   r = h[1];
            SRC_H2:   r = h[2];
            SRC_Q0:   r = q[0];
            SRC_Q1:   r = q[1];
            SRC_Q2:   r = q[2];
            default:  r = '0;
        endcase
        return r;
    endfunction

    always_comb
    begin
        uop = uop_rom(ctrl.step);
        opa = pick(uop.a, dir, e1_reg, e2_reg, s_reg, h_reg, q_reg);
        opb = pick(uop.b, dir, e1_reg, e2_reg, s_reg, h_reg, q_reg);
    end

    assign prod_ext = ACC_W'(prod_reg);
    assign dterm    = ACC_W'(prod_reg >>> FRAC_BITS);   // arithmetic shift = floor

    always_comb
    begin
        unique case (op_reg.op)
            OP_CLOAD: acc_next = prod_ext;
            OP_CSUB:  acc_next = acc_reg - prod_ext;
            OP_DLOAD: acc_next = dterm;
            OP_DADD,
            OP_DEND:  acc_next = acc_reg + dterm;
            default:  acc_next = acc_reg;
        endcase
    end

    assign cross_val = sat_coord(acc_next >>> FRAC_BITS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            opv_reg <= 1'b0;
        else
            opv_reg <= ctrl.issue;
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            e1_reg <= e1;
            e2_reg <= e2;
            s_reg  <= sv;
        end
        prod_reg <= $signed(opa) * $signed(opb);
        op_reg   <= uop;
        if (opv_reg)
        begin
            acc_reg <= acc_next;
            if (op_reg.op == OP_CSUB)
            begin
                unique case (op_reg.cdst)
                    SRC_H0:  h_reg[0] <= cross_val;
                    SRC_H1:  h_reg[1] <= cross_val;
                    SRC_H2:  h_reg[2] <= cross_val;
                    SRC_Q0:  q_reg[0] <= cross_val;
                    SRC_Q1:  q_reg[1] <= cross_val;
                    SRC_Q2:  q_reg[2] <= cross_val;
                    default: ;
                endcase
            end
            if (op_reg.op == OP_DEND)
            begin
                unique case (op_reg.ddst)
                    DD_DET: det_reg <= acc_next[DOT_W-1:0];
                    DD_UN:  un_reg  <= acc_next[DOT_W-1:0];
                    DD_VN:  vn_reg  <= acc_next[DOT_W-1:0];
                    DD_TN:  tn_reg  <= acc_next[DOT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    assign det = det_reg;
    assign un  = un_reg;
    assign vn  = vn_reg;
    assign tn  = tn_reg;

endmodule

/* rtl/core/rtnh_div.sv */
// Restoring divider, one quotient bit per cycle, for the hit distance.
// Depends on rtnh_pkg. Requires num < den at start.
module rtnh_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rtnh_pkg::DIV_W-1:0]    num,
    input  logic [rtnh_pkg::DIV_W-1:0]    den,
    output rtnh_pkg::div_stat_t           stat,
    output logic [rtnh_pkg::DIST_W-1:0]   quot
);
    import rtnh_pkg::*;

    logic [DIV_W-1:0]  r_reg, d_reg;
    logic [DIV_W:0]    r2, diff;
    logic              ge;
    logic [DIST_W-1:0] q_reg;
    logic [DCNT_W-1:0] cnt_reg;
    logic              busy_reg, done_reg;

    assign r2   = {r_reg, 1'b0};
    assign diff = r2 - {1'b0, d_reg};
    assign ge   = !diff[DIV_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == DCNT_W'(DIST_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            r_reg <= num;
            d_reg <= den;
        end
        else if (busy_reg)
        begin
            r_reg <= ge ? diff[DIV_W-1:0] : r2[DIV_W-1:0];
            q_reg <= {q_reg[DIST_W-2:0], ge};
        end
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quot      = q_reg;

endmodule

/* rtl/core/ray_triangle_nearest_hit_unit.sv */
// Top level of the ray/triangle nearest-hit unit: sequencer, tests, nearest-hit state.
// Depends on rtnh_pkg, rtnh_mac, rtnh_div and the assertion macro header.
//
//  channel   dir  handshake             payload
//  cfg       in   cfg_we                cfg_index, cfg_data
//  s_axis    in   tvalid/tready         tdata (vertices, owner_tag), tlast
//  m_axis    out  tvalid/tready         tdata (hit, distances, tag), tlast
//
// One triangle at a time: the shared multiplier (24 products) and the
// one-bit-per-cycle divider set the time from transfer to result, which is
// longer when the distance is divided.
// Reset returns the control, configuration and nearest-hit registers to their reset values and clears the nearest hit.
// A result waiting in the output register holds the sequencer in its last state
// only; the next triangle is taken as soon as that result has been written there.
`include "ray_triangle_nearest_hit_unit_assert.svh"

module ray_triangle_nearest_hit_unit #(
    parameter int TAG_BITS = rtnh_pkg::TAG_BITS_DEF,
    localparam int IN_W  = ((9 * rtnh_pkg::COORD_W + TAG_BITS + 7) / 8) * 8,
    localparam int OUT_W = ((2 * rtnh_pkg::DIST_W + 2 + TAG_BITS + 7) / 8) * 8
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rtnh_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rtnh_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    // v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z, owner_tag
    input  logic [IN_W-1:0]                   s_axis_tdata,
    input  logic                              s_axis_tlast,    // last_triangle
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    // tri_hit, tri_distance, nearest_valid, nearest_distance, nearest_tag
    output logic [OUT_W-1:0]                  m_axis_tdata,
    output logic                              m_axis_tlast     // final_result
);
    import rtnh_pkg::*;

    state_t                   state_reg, state_next;
    logic [STEP_W-1:0]        step_reg;
    logic [2:0][COORD_W-1:0]  org_reg, dir_reg;
    logic [COORD_W-1:0]       thr_reg;
    logic [DIST_W-1:0]        min_reg;

    logic [8:0][COORD_W-1:0]  vert;
    logic [2:0][COORD_W-1:0]  e1, e2, sv;
    logic [TAG_BITS-1:0]      tag_reg;
    logic                     last_reg;

    mac_ctrl_t                mac_ctrl;
    logic signed [DOT_W-1:0]  det, un, vn, tn;
    logic signed [DOT_W-1:0]  det_n_reg, un_n_reg, vn_n_reg, tn_n_reg;
    logic                     par_reg;
    logic signed [DOT_W-1:0]  det_abs;
    logic signed [DOT_W:0]    uv_sum;
    logic                     miss, sat;
    logic [DIV_W-1:0]         den, num;

    div_stat_t                div_stat;
    logic                     div_start;
    logic [DIST_W-1:0]        quot;
    logic                     cand_reg;
    logic [DIST_W-1:0]        t_reg;

    logic                     best_valid_reg;
    logic [DIST_W-1:0]        best_dist_reg;
    logic [TAG_BITS-1:0]      best_tag_reg;
    logic                     hit, upd, out_free, out_load;
    logic                     nv;
    logic [DIST_W-1:0]        nd;
    logic [TAG_BITS-1:0]      ntag;

    logic                     o_hit_reg, o_nv_reg, o_last_reg, m_valid_reg;
    logic [DIST_W-1:0]        o_tdist_reg, o_ndist_reg;
    logic [TAG_BITS-1:0]      o_ntag_reg;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg <= '0;
            dir_reg <= '{COORD_W'(1) << FRAC_BITS, '0, '0};
            thr_reg <= '0;
            min_reg <= DIST_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                CFG_ORIGIN_X: org_reg[0] <= cfg_data;
                CFG_ORIGIN_Y: org_reg[1] <= cfg_data;
                CFG_ORIGIN_Z: org_reg[2] <= cfg_data;
                CFG_DIR_X:    dir_reg[0] <= cfg_data;
                CFG_DIR_Y:    dir_reg[1] <= cfg_data;
                CFG_DIR_Z:    dir_reg[2] <= cfg_data;
                CFG_DET_THR:  thr_reg    <= cfg_data;
                CFG_MIN_DIST: min_reg    <= cfg_data[DIST_W-1:0];
                default: ;
            endcase
        end
    end

    // edges and origin offset, saturated, formed on the input transfer
    assign vert = s_axis_tdata[9*COORD_W-1:0];
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            e1[i] = sat_coord(ACC_W'($signed(vert[3+i])) - ACC_W'($signed(vert[i])));
            e2[i] = sat_coord(ACC_W'($signed(vert[6+i])) - ACC_W'($signed(vert[i])));
            sv[i] = sat_coord(ACC_W'($signed(org_reg[i])) - ACC_W'($signed(vert[i])));
        end
    end

    rtnh_mac u_mac (
        .clk  (clk),
        .rst_n(rst_n),
        .ctrl (mac_ctrl),
        .dir  (dir_reg),
        .e1   (e1),
        .e2   (e2),
        .sv   (sv),
        .det  (det),
        .un   (un),
        .vn   (vn),
        .tn   (tn)
    );

    // tests on the sign-normalised numerators
    assign det_abs = det[DOT_W-1] ? -det : det;
    assign uv_sum  = (DOT_W+1)'(un_n_reg) + (DOT_W+1)'(vn_n_reg);
    assign miss    = par_reg || un_n_reg[DOT_W-1] || (un_n_reg > det_n_reg)
                     || vn_n_reg[DOT_W-1] || (uv_sum > (DOT_W+1)'(det_n_reg))
                     || tn_n_reg[DOT_W-1];
    assign den     = DIV_W'($unsigned(det_n_reg)) << DSHIFT;
    assign num     = DIV_W'($unsigned(tn_n_reg));
    assign sat     = num >= den;   // t would reach 2^31

    rtnh_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (num),
        .den  (den),
        .stat (div_stat),
        .quot (quot)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (s_axis_tvalid) state_next = ST_CALC;
            ST_CALC: if (step_reg == STEP_W'(NUM_STEPS)) state_next = ST_NORM;
            ST_NORM: state_next = ST_TEST;
            ST_TEST: state_next = (miss || sat) ? ST_DONE : ST_DIV;
            ST_DIV:  if (div_stat.done) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    assign out_free = !m_valid_reg || m_axis_tready;

    // control outputs
    always_comb
    begin
        s_axis_tready  = (state_reg == ST_IDLE);
        mac_ctrl.load  = (state_reg == ST_IDLE) && s_axis_tvalid;
        mac_ctrl.issue = (state_reg == ST_CALC) && (step_reg != STEP_W'(NUM_STEPS));
        mac_ctrl.step  = step_reg;
        div_start      = (state_reg == ST_TEST) && !miss && !sat;
        out_load       = (state_reg == ST_DONE) && out_free;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == ST_CALC)
                step_reg <= step_reg + 1'b1;
            else
                step_reg <= '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mac_ctrl.load)
        begin
            tag_reg  <= s_axis_tdata[9*COORD_W +: TAG_BITS];
            last_reg <= s_axis_tlast;
        end
        if (state_reg == ST_NORM)
        begin
            par_reg   <= DOT_W'($unsigned(det_abs)) <= DOT_W'(thr_reg);
            det_n_reg <= det_abs;
            un_n_reg  <= det[DOT_W-1] ? -un : un;
            vn_n_reg  <= det[DOT_W-1] ? -vn : vn;
            tn_n_reg  <= det[DOT_W-1] ? -tn : tn;
        end
        if (state_reg == ST_TEST)
        begin
            cand_reg <= !miss;
            t_reg    <= DIST_MAX;
        end
        if ((state_reg == ST_DIV) && div_stat.done)
            t_reg <= quot;
    end

    // nearest-hit update; ties keep the earlier hit
    always_comb
    begin
        hit  = cand_reg && (t_reg >= min_reg);
        upd  = hit && (!best_valid_reg || (t_reg < best_dist_reg));
        nv   = best_valid_reg || hit;
        nd   = upd ? t_reg : best_dist_reg;
        ntag = upd ? tag_reg : best_tag_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_valid_reg <= 1'b0;
            best_dist_reg  <= '0;
            best_tag_reg   <= '0;
            m_valid_reg    <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                m_valid_reg <= 1'b1;
                if (last_reg)
                begin
                    best_valid_reg <= 1'b0;
                    best_dist_reg  <= '0;
                    best_tag_reg   <= '0;
                end
                else if (upd)
                begin
                    best_valid_reg <= 1'b1;
                    best_dist_reg  <= t_reg;
                    best_tag_reg   <= tag_reg;
                end
            end
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_hit_reg   <= hit;
            o_tdist_reg <= hit ? t_reg : '0;
            o_nv_reg    <= nv;
            o_ndist_reg <= nd;
            o_ntag_reg  <= ntag;
            o_last_reg  <= last_reg;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = OUT_W'({o_ntag_reg, o_ndist_reg, o_nv_reg, o_tdist_reg, o_hit_reg});
    assign m_axis_tlast  = o_last_reg;

    `RTNH_ASSERT_NOW(a_div_done_in_div, div_stat.done, state_reg == ST_DIV, "divider done outside DIV")
    `RTNH_ASSERT_NEXT(a_accept_starts, s_axis_tvalid && s_axis_tready, (state_reg == ST_CALC) && (step_reg == '0), "transfer did not start sequence")
    `RTNH_ASSERT_NOW(a_best_clear, !best_valid_reg, (best_dist_reg == '0) && (best_tag_reg == '0), "stale nearest state")
    `RTNH_ASSERT_NOW(a_nearest_le_hit, m_valid_reg && o_hit_reg, o_nv_reg && (o_ndist_reg <= o_tdist_reg), "nearest farther than hit")

endmodule
